### rtl/ibw_pkg.sv
// Package for the bit-banged I2C byte writer: register indexes, constants
// and the job record that passes from the front end to the line sequencer.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ibw_pkg;

  // Configuration register indexes
  localparam int RegIndexW = 1;
  localparam logic [RegIndexW-1:0] REG_SLAVE_ADDRESS = 1'b0;
  localparam logic [RegIndexW-1:0] REG_BACKLIGHT_ON  = 1'b1;

  // Widths of the configuration registers and of the write data
  localparam int AddrW      = 7;
  localparam int WriteDataW = 7;
  localparam int ByteW      = 8;

  // Reset values of the registers
  localparam logic [AddrW-1:0] SLAVE_ADDRESS_RESET = 7'd39;
  localparam logic             BACKLIGHT_RESET     = 1'b1;

  // Byte framing
  localparam logic             WRITE_BIT      = 1'b0;
  localparam logic [ByteW-1:0] BACKLIGHT_MASK = 8'h08;

  // Bit slot of a byte that carries the released-SDA acknowledge clock
  localparam logic [3:0] ACK_SLOT = 4'd8;

  // Depth of the queue between the front end and the sequencer
  localparam int QueueDepth = 2;

  // One transaction as it waits to go out on the lines
  typedef struct packed {
    logic [ByteW-1:0] addr_byte;
    logic [ByteW-1:0] data_byte;
  } ibw_job_t;

endpackage : ibw_pkg

`default_nettype wire

### rtl/ibw_if.sv
// Valid/ready channel interfaces of the I2C byte writer: the expander byte
// input and the line state output. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface ibw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] expander_byte;

  modport source (output valid, output expander_byte, input ready);
  modport sink   (input valid, input expander_byte, output ready);
endinterface : ibw_byte_if

interface ibw_line_if;
  logic valid;
  logic ready;
  logic sda_level;
  logic scl_level;
  logic last_step;

  modport source (output valid, output sda_level, output scl_level, output last_step,
                  input ready);
  modport sink   (input valid, input sda_level, input scl_level, input last_step,
                  output ready);
endinterface : ibw_line_if

`default_nettype wire

### rtl/ibw_front.sv
// Front end of the I2C byte writer: configuration registers, acceptance of
// expander bytes and assembly of the address and data bytes of a job.
// Depends on ibw_pkg and ibw_if.
`timescale 1ns / 1ps
`default_nettype none

module ibw_front
  import ibw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 write_enable,
  input  wire logic [RegIndexW-1:0] reg_index,
  input  wire logic [WriteDataW-1:0] write_data,
  ibw_byte_if.sink                  expander,
  output      logic                 push_valid,
  input  wire logic                 push_ready,
  output      ibw_job_t             push_job
);

  logic [AddrW-1:0] slave_address;
  logic             backlight_on;

  // Configuration writes; an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDRESS_RESET;
      backlight_on  <= BACKLIGHT_RESET;
    end else if (write_enable) begin
      case (reg_index)
        REG_SLAVE_ADDRESS: slave_address <= write_data[AddrW-1:0];
        REG_BACKLIGHT_ON:  backlight_on  <= write_data[0];
        default: ;
      endcase
    end
  end

  // A transaction is taken whenever the queue has room for it.
  assign expander.ready = push_ready;
  assign push_valid     = expander.valid;

  // Address byte carries the write bit; the backlight bit is forced into the data byte.
  always_comb begin
    push_job.addr_byte = {slave_address, WRITE_BIT};
    push_job.data_byte = expander.expander_byte | (backlight_on ? BACKLIGHT_MASK : '0);
  end

endmodule : ibw_front

`default_nettype wire

### rtl/ibw_queue.sv
// Short job queue between the front end and the line sequencer of the
// I2C byte writer. Depends on ibw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibw_queue
  import ibw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push_valid,
  output      logic     push_ready,
  input  wire ibw_job_t push_job,
  output      logic     pop_valid,
  input  wire logic     pop_ready,
  output      ibw_job_t pop_job
);

  localparam int PtrW   = $clog2(QueueDepth);
  localparam int CountW = $clog2(QueueDepth + 1);

  ibw_job_t            entries [QueueDepth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CountW-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != CountW'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage for queued jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule : ibw_queue

`default_nettype wire

### rtl/ibw_back.sv
// Line sequencer of the I2C byte writer: turns one queued job into the 60
// SDA/SCL states of a write transaction, one state per output transaction.
// Depends on ibw_pkg and ibw_if.
`timescale 1ns / 1ps
`default_nettype none

module ibw_back
  import ibw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     job_valid,
  output      logic     job_ready,
  input  wire ibw_job_t job,
  ibw_line_if.source    lines
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_ADDR  = 5'b00100,
    S_DATA  = 5'b01000,
    S_STOP  = 5'b10000
  } seq_state_t;

  // Three line states per bit: data set, clock high, clock low
  localparam logic [1:0] PH_SET  = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  seq_state_t        state;
  logic [1:0]        phase;
  logic [3:0]        bit_cnt;
  logic [ByteW-1:0]  shift_byte;
  logic [ByteW-1:0]  held_data;
  logic              out_load;
  logic              step_go;
  logic              seq_end;
  logic              sda_next;
  logic              scl_next;
  logic              last_next;

  // The output register frees up when empty or when its state is taken.
  assign out_load  = !lines.valid || lines.ready;
  assign step_go   = (state != S_IDLE) && out_load;
  assign seq_end   = step_go && (state == S_STOP) && (phase == PH_LOW);
  assign job_ready = (state == S_IDLE) || seq_end;

  // Line levels of the current step
  always_comb begin
    sda_next  = 1'b1;
    scl_next  = 1'b1;
    last_next = 1'b0;
    case (state)
      S_START: begin
        sda_next = (phase == PH_SET);
        scl_next = (phase != PH_LOW);
      end
      S_ADDR, S_DATA: begin
        sda_next = (bit_cnt == ACK_SLOT) ? 1'b1 : shift_byte[ByteW-1];
        scl_next = (phase == PH_HIGH);
      end
      S_STOP: begin
        sda_next  = (phase == PH_LOW);
        scl_next  = (phase != PH_SET);
        last_next = (phase == PH_LOW);
      end
      default: ;
    endcase
  end

  // Sequencer: a new job starts in the cycle after the previous stop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= PH_SET;
      bit_cnt <= '0;
    end else if (job_valid && job_ready) begin
      state   <= S_START;
      phase   <= PH_SET;
      bit_cnt <= '0;
    end else if (seq_end) begin
      state <= S_IDLE;
    end else if (step_go) begin
      if (phase != PH_LOW) begin
        phase <= phase + 1'b1;
      end else begin
        phase <= PH_SET;
        case (state)
          S_START: state <= S_ADDR;
          S_ADDR, S_DATA: begin
            if (bit_cnt == ACK_SLOT) begin
              bit_cnt <= '0;
              state   <= (state == S_ADDR) ? S_DATA : S_STOP;
            end else begin
              bit_cnt <= bit_cnt + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Shift register for the byte on the wire and the waiting data byte
  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      shift_byte <= job.addr_byte;
      held_data  <= job.data_byte;
    end else if (step_go && (phase == PH_LOW)) begin
      if ((state == S_ADDR) && (bit_cnt == ACK_SLOT)) begin
        shift_byte <= held_data;
      end else if ((state == S_ADDR) || (state == S_DATA)) begin
        shift_byte <= {shift_byte[ByteW-2:0], 1'b0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      lines.valid <= 1'b0;
    end else if (step_go) begin
      lines.valid <= 1'b1;
    end else if (lines.ready) begin
      lines.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      lines.sda_level <= sda_next;
      lines.scl_level <= scl_next;
      lines.last_step <= last_next;
    end
  end

  // The final stop state leaves both lines released.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    lines.valid && lines.last_step |-> lines.sda_level && lines.scl_level)
    else $error("last step without both lines high");

  // The bit counter never passes the acknowledge slot.
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_cnt <= ACK_SLOT)
    else $error("bit counter out of range");

  // SDA only changes while SCL is low inside a byte.
  a_sda_stable: assert property (@(posedge clk) disable iff (rst)
    step_go && (state == S_ADDR || state == S_DATA) && phase == PH_HIGH
      |-> sda_next == lines.sda_level)
    else $error("data line moved while clock high");

  // A job is only taken when the sequencer is idle or closing a transaction.
  a_take_job: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready |=> state == S_START && phase == PH_SET)
    else $error("job start did not begin with a start condition");

endmodule : ibw_back

`default_nettype wire

### rtl/i2c_bitbang_byte_writer.sv
// I2C byte writer for an I/O expander (bit-banged line states).
//
// The expander channel takes one byte per transaction. Each byte becomes
// one I2C write: a start, the address byte (slave address, write bit),
// the data byte with the backlight bit forced when enabled, then a stop.
// Every line state (SDA, SCL) leaves on the lines channel as one
// transaction, 60 per byte; last_step marks the final stop state.
// Configuration registers are written through write_enable, reg_index and
// write_data: index 0 is the slave address, index 1 the backlight enable.
// A byte goes through the queue, the sequencer state and the output
// register before its first line state is valid. The sequencer issues one
// line state per cycle unless stalled, with no gap between bytes.
// A two-entry queue lets bytes be accepted while a transaction is running.
// When the receiver stalls, the current state holds in the output
// register and the sequencer waits; the queue then fills and the
// expander channel drops ready.
// Reset (synchronous, active high) empties the queue and the output, and
// loads address 39 with the backlight enabled.
// Depends on ibw_pkg, ibw_if, ibw_front, ibw_queue and ibw_back.
`timescale 1ns / 1ps
`default_nettype none

module i2c_bitbang_byte_writer
  import ibw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  write_enable,
  input  wire logic [RegIndexW-1:0]  reg_index,
  input  wire logic [WriteDataW-1:0] write_data,
  ibw_byte_if.sink                   expander,
  ibw_line_if.source                 lines
);

  logic     push_valid;
  logic     push_ready;
  ibw_job_t push_job;
  logic     job_valid;
  logic     job_ready;
  ibw_job_t job;

  // Configuration and job assembly
  ibw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .expander     (expander),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_job     (push_job)
  );

  // Queue between the front end and the sequencer
  ibw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (job_valid),
    .pop_ready  (job_ready),
    .pop_job    (job)
  );

  // Line state sequencer
  ibw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .lines     (lines)
  );

endmodule : i2c_bitbang_byte_writer

`default_nettype wire

### tb/sv/ibw_line_checker.sv
// Checker for the I2C byte writer: watches the register port and both channels,
// predicts the 60 line states of every expander byte and compares them in order.
// Depends on ibw_pkg and the channel interfaces in ibw_if.
`timescale 1ns / 1ps

module ibw_line_checker
  import ibw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_enable,
  input  logic [RegIndexW-1:0]  reg_index,
  input  logic [WriteDataW-1:0] write_data,
  ibw_byte_if                   byte_ch,
  ibw_line_if                   line_ch,
  output int                    mismatch_count,
  output int                    states_pending,
  output int                    states_checked
);

  // Line level bits as the predictor keeps them: bit 0 is SDA, bit 1 is SCL.
  localparam logic [1:0] SDA_MASK  = 2'b01;
  localparam logic [1:0] SCL_MASK  = 2'b10;
  localparam logic [1:0] BOTH_HIGH = 2'b11;
  localparam logic [1:0] BOTH_LOW  = 2'b00;

  localparam logic [7:0] BACKLIGHT_BIT    = 8'h08;
  localparam logic [6:0] ADDR_AFTER_RESET = 7'd39;
  localparam logic [5:0] FINAL_STEP       = 6'd59;
  localparam int         MAX_PRINTED      = 40;

  typedef struct packed {
    logic sda;
    logic scl;
    logic last;
  } line_state_t;

  line_state_t expected_states[$];

  // Predictor copy of the registers and of the line sequencer.
  logic [6:0] addr_cfg;
  logic       backlight_cfg;
  logic [1:0] line_lv;
  logic [5:0] step_no;

  initial begin
    mismatch_count = 0;
    states_pending = 0;
    states_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Put one line state on the lines and queue it as expected.
  task automatic emit_state(input logic [1:0] lv);
    line_state_t s;
    line_lv = lv;
    s.sda  = line_lv[0];
    s.scl  = line_lv[1];
    s.last = (step_no == FINAL_STEP);
    expected_states.push_back(s);
    step_no = step_no + 6'd1;
  endtask

  // One byte, MSB first, three states a bit, then the released-SDA ACK clock.
  task automatic shift_out(input logic [7:0] value);
    logic [7:0] sh;
    sh = value;
    for (int i = 0; i < 8; i++) begin
      emit_state({1'b0, sh[7]});
      emit_state(line_lv | SCL_MASK);
      emit_state(line_lv & ~SCL_MASK);
      sh = sh << 1;
    end
    emit_state(line_lv | SDA_MASK);
    emit_state(line_lv | SCL_MASK);
    emit_state(line_lv & ~SCL_MASK);
  endtask

  // Whole write transaction for one expander byte: start, address, data, stop.
  task automatic predict_write(input logic [7:0] raw);
    logic [7:0] data_b;
    data_b = raw;
    if (backlight_cfg) begin
      data_b = data_b | BACKLIGHT_BIT;
    end
    step_no = '0;
    emit_state(BOTH_HIGH);
    emit_state(SCL_MASK);
    emit_state(BOTH_LOW);
    shift_out({addr_cfg, 1'b0});
    shift_out(data_b);
    emit_state(line_lv & ~SDA_MASK);
    emit_state(line_lv | SCL_MASK);
    emit_state(line_lv | SDA_MASK);
    step_no = '0;
  endtask

  // Sample everything at the rising edge; the stimulus moves at the falling one.
  always @(posedge clk) begin
    line_state_t want;
    if (rst) begin
      addr_cfg      = ADDR_AFTER_RESET;
      backlight_cfg = 1'b1;
      line_lv       = BOTH_HIGH;
      step_no       = '0;
    end else begin
      if (write_enable) begin
        case (reg_index)
          REG_SLAVE_ADDRESS: addr_cfg      = write_data[6:0];
          REG_BACKLIGHT_ON:  backlight_cfg = write_data[0];
          default: ;
        endcase
      end

      if (byte_ch.valid && byte_ch.ready) begin
        predict_write(byte_ch.expander_byte);
      end

      if (line_ch.valid && line_ch.ready) begin
        if (expected_states.size() == 0) begin
          report_mismatch($sformatf("line state sda %b scl %b last %b with none expected",
                                    line_ch.sda_level, line_ch.scl_level, line_ch.last_step));
        end else begin
          want = expected_states.pop_front();
          if (line_ch.sda_level !== want.sda) begin
            report_mismatch($sformatf("state %0d: sda_level %b, expected %b",
                                      states_checked, line_ch.sda_level, want.sda));
          end
          if (line_ch.scl_level !== want.scl) begin
            report_mismatch($sformatf("state %0d: scl_level %b, expected %b",
                                      states_checked, line_ch.scl_level, want.scl));
          end
          if (line_ch.last_step !== want.last) begin
            report_mismatch($sformatf("state %0d: last_step %b, expected %b",
                                      states_checked, line_ch.last_step, want.last));
          end
        end
        states_checked++;
      end
    end
    states_pending = expected_states.size();
  end

endmodule : ibw_line_checker

### tb/sv/tb_i2c_bitbang_byte_writer.sv
// Testbench top for the I2C byte writer: clock, reset, register writes and
// expander bytes with random idling on both channels; checking is in ibw_line_checker.
// Depends on ibw_pkg, ibw_if, ibw_line_checker and the block itself.
`timescale 1ns / 1ps

module tb_i2c_bitbang_byte_writer
  import ibw_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 77;
  localparam int RAND_PHASES  = 6;
  localparam int IDLE_PERCENT = 16;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  write_enable = 1'b0;
  logic [RegIndexW-1:0]  reg_index = '0;
  logic [WriteDataW-1:0] write_data = '0;

  // Traffic shaping: calm removes idling on both sides, hold_rx stalls the receiver.
  logic calm    = 1'b0;
  logic hold_rx = 1'b0;

  int mismatches;
  int pending;
  int checked;
  int bytes_sent   = 0;
  int settings_run = 0;
  int cycle_count  = 0;

  ibw_byte_if expander ();
  ibw_line_if lines ();

  initial begin
    expander.valid         = 1'b0;
    expander.expander_byte = '0;
    lines.ready            = 1'b0;
  end

  i2c_bitbang_byte_writer u_dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .expander     (expander),
    .lines        (lines)
  );

  ibw_line_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .reg_index      (reg_index),
    .write_data     (write_data),
    .byte_ch        (expander),
    .line_ch        (lines),
    .mismatch_count (mismatches),
    .states_pending (pending),
    .states_checked (checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_i2c_bitbang_byte_writer: FAIL");
    $finish;
  end

  // Receiver side: random stalls, none while calm, solid stall while held off.
  always @(negedge clk) begin
    if (hold_rx) begin
      lines.ready <= 1'b0;
    end else if (calm) begin
      lines.ready <= 1'b1;
    end else begin
      lines.ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Write both registers, one per cycle, while the block is idle.
  task automatic apply_setting(input logic [6:0] addr, input logic bl);
    write_enable <= 1'b1;
    reg_index    <= REG_SLAVE_ADDRESS;
    write_data   <= addr;
    @(negedge clk);
    reg_index    <= REG_BACKLIGHT_ON;
    write_data   <= {6'($urandom), bl};
    @(negedge clk);
    write_enable <= 1'b0;
    settings_run++;
  endtask

  // Offer one byte and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      expander.valid         <= 1'b0;
      expander.expander_byte <= 8'($urandom);
      @(negedge clk);
    end
    expander.valid         <= 1'b1;
    expander.expander_byte <= b;
    do begin
      @(posedge clk);
    end while (!expander.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Every expected line state has gone out before the registers change.
  task automatic wait_drained();
    expander.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic send_directed(input logic [7:0] list[$]);
    foreach (list[i]) begin
      send_byte(list[i]);
    end
  endtask

  initial begin
    logic [7:0] edge_bytes[$];
    logic [7:0] pick;
    logic [6:0] addr;
    logic       bl;

    edge_bytes = '{8'h00, 8'hFF, 8'h08, 8'hF7, 8'h80, 8'h01, 8'hAA, 8'h55};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset values first, then address 0 with the backlight off
    // and address 127 with the backlight on and then off.
    settings_run = 1;
    send_directed(edge_bytes);
    wait_drained();
    apply_setting(7'd0, 1'b0);
    send_directed(edge_bytes);
    wait_drained();
    apply_setting(7'd127, 1'b1);
    send_directed('{8'h00, 8'hFF, 8'h5A});
    wait_drained();
    apply_setting(7'd127, 1'b0);
    send_directed('{8'hF7, 8'h08});
    wait_drained();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        addr = 7'd0;
        bl   = 1'b1;
      end else if (ph == RAND_PHASES - 1) begin
        addr = 7'd127;
        bl   = 1'b0;
      end else begin
        addr = 7'($urandom);
        bl   = 1'($urandom);
      end
      apply_setting(addr, bl);

      // A stretch with no idling on either channel.
      calm <= (ph == 3);

      // Long receiver hold-off while bytes keep coming, so the queue fills.
      if (ph == 2) begin
        hold_rx <= 1'b1;
        fork
          begin
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_rx <= 1'b0;
          end
        join_none
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(7) == 0) begin
          pick = $urandom_range(1) ? 8'hFF : 8'h00;
        end else begin
          pick = 8'($urandom_range(255));
        end
        send_byte(pick);
      end
      wait_drained();
    end

    calm <= 1'b0;
    repeat (10) @(negedge clk);

    $display("Run covered %0d expander bytes under %0d register settings, %0d line states checked.",
             bytes_sent, settings_run, checked);
    $display("It included a %0d-cycle receiver hold-off and a stretch with no idling at all.",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_i2c_bitbang_byte_writer: PASS");
    end else begin
      $display("tb_i2c_bitbang_byte_writer: FAIL");
    end
    $finish;
  end

endmodule : tb_i2c_bitbang_byte_writer

### sim.f
rtl/ibw_pkg.sv
rtl/ibw_if.sv
rtl/ibw_front.sv
rtl/ibw_queue.sv
rtl/ibw_back.sv
rtl/i2c_bitbang_byte_writer.sv
tb/sv/ibw_line_checker.sv
tb/sv/tb_i2c_bitbang_byte_writer.sv
